/* hw/rtl/gas_sensor_uart_frame_parser_assert.svh */
// ----------------------------------------------------------------------------
// gas sensor uart frame parser assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_UART_FRAME_PARSER_ASSERT_SVH
`define GAS_SENSOR_UART_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define GSUFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsufp check failed");

`define GSUFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsufp check failed");

`else

`define GSUFP_ASSERT_NOW(label, clk, rst, ante, cons)

`define GSUFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/gsufp_pkg.sv */
// ----------------------------------------------------------------------------
// gsufp_pkg
// shared types, codes and the query frame table of the frame parser
// ----------------------------------------------------------------------------
package gsufp_pkg;

   typedef enum logic [1:0] {
      RK_OK      = 2'd0,
      RK_FAULT   = 2'd1,
      RK_TIMEOUT = 2'd2,
      RK_QUERY   = 2'd3
   } rkind_type;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [1:0] REG_QUERY_INTERVAL = 2'd0;
   localparam logic [1:0] REG_TIMEOUT        = 2'd1;
   localparam logic [1:0] REG_INVALID_PPM    = 2'd2;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   localparam logic [15:0] QUERY_INTERVAL_RESET = 16'd1200;
   localparam logic [15:0] TIMEOUT_RESET        = 16'd5000;
   localparam logic [15:0] INVALID_PPM_RESET    = 16'hFFFF;

   localparam logic [7:0] START_BYTE  = 8'hFF;
   localparam logic [7:0] TYPE_QUERY  = 8'h86;
   localparam logic [7:0] TYPE_UPLOAD = 8'h01;
   localparam logic [7:0] CMD_UPLOAD  = 8'h03;

   localparam logic [3:0] POS_HUNT     = 4'd0;
   localparam logic [3:0] POS_FIRST    = 4'd1;
   localparam logic [3:0] POS_LAST_ST  = 4'd5;
   localparam logic [3:0] POS_LAST_SUM = 4'd7;

   localparam logic [3:0] SLOT_FIRST   = 4'd0;
   localparam logic [3:0] SLOT_QLAST   = 4'd8;
   localparam logic [3:0] SLOT_TIMEOUT = 4'd9;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [12:0] conc;
   } frame_type;

   function automatic logic [7:0] query_byte(input logic [3:0] slot);
      logic [7:0] b;
      unique case (slot)
         4'd0:    b = 8'hFF;
         4'd1:    b = 8'h01;
         4'd2:    b = 8'h86;
         4'd8:    b = 8'h79;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* hw/rtl/gsufp_parser.sv */
// ----------------------------------------------------------------------------
// gsufp_parser
// start byte hunt, frame capture, checksum and frame type check
// ----------------------------------------------------------------------------
module gsufp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_en,
   input  logic [7:0]          rx_byte,
   output gsufp_pkg::frame_type frame
);
   import gsufp_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] store_ff [5];
   logic [7:0] sum_add;
   logic [2:0] wr_idx;

   assign sum_add = sum_ff + rx_byte;
   assign wr_idx  = 3'(pos_ff - POS_FIRST);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      frame  = '0;
      if (byte_en) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == START_BYTE) begin
               pos_in = POS_FIRST;
               sum_in = 8'd0;
            end
         end else if (pos_ff <= POS_LAST_SUM) begin
            sum_in = sum_add;
            pos_in = pos_ff + 4'd1;
         end else begin
            pos_in = POS_HUNT;
            // checksum good when sum plus check byte wraps to zero
            if (sum_add == 8'd0) begin
               if (store_ff[0] == TYPE_QUERY) begin
                  frame.valid = 1'b1;
                  frame.fault = store_ff[1][7];
                  frame.conc  = {store_ff[1][4:0], store_ff[2]};
               end else if (store_ff[0] == TYPE_UPLOAD && store_ff[1] == CMD_UPLOAD) begin
                  frame.valid = 1'b1;
                  frame.fault = store_ff[3][7];
                  frame.conc  = {store_ff[3][4:0], store_ff[4]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_en && pos_ff >= POS_FIRST && pos_ff <= POS_LAST_ST) begin
         store_ff[wr_idx] <= rx_byte;
      end
   end

endmodule

/* hw/rtl/gas_sensor_uart_frame_parser.sv */
// ----------------------------------------------------------------------------
// gas_sensor_uart_frame_parser
// parses 9-byte sensor frames and schedules query frames and timeouts
//
// channel  dir  content
// req      in   tuser kind, tdata rx_byte
// rsp      out  tuser result_kind, tdata ppm and tx_byte, tlast last
// csr      in   query interval, timeout and invalid ppm registers
//
// a request's results are registered in the cycle after it is taken
// a byte gives at most one result, a tick up to ten, one result per cycle while rsp_tready is high
// a new request is taken once the last result of the previous one leaves
// reset is synchronous and restores the register defaults, no clearing pass
// ----------------------------------------------------------------------------
`include "gas_sensor_uart_frame_parser_assert.svh"

module gas_sensor_uart_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // rx_byte
   input  logic                                req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // ppm, tx_byte
   output logic [1:0]                          rsp_tuser,  // result_kind
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gsufp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import gsufp_pkg::*;

   logic [15:0] interval_ff, timeout_ff, invalid_ff;
   logic [1:0]  reg_idx;
   logic        csr_wr;

   logic        accept, byte_en, tick_en;
   frame_type   frame;

   logic [15:0] tsq_ff, tsq_in, tsq_inc;
   logic [15:0] tsf_ff, tsf_in, tsf_inc;
   logic        never_ff, never_in;
   logic        due, tmo;

   logic        busy_ff, busy_in;
   logic        single_ff, single_in;
   rkind_type   fkind_ff, fkind_in;
   logic [15:0] fppm_ff, fppm_in;
   logic [3:0]  slot_ff, slot_in;
   logic        tmo_ff, tmo_in;
   logic        out_last, out_free;
   rkind_type   out_kind;
   logic [15:0] out_ppm;
   logic [7:0]  out_tx;

   // configuration
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (reg_idx)
         REG_QUERY_INTERVAL: csr_prdata = {16'd0, interval_ff};
         REG_TIMEOUT:        csr_prdata = {16'd0, timeout_ff};
         REG_INVALID_PPM:    csr_prdata = {16'd0, invalid_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= QUERY_INTERVAL_RESET;
         timeout_ff  <= TIMEOUT_RESET;
         invalid_ff  <= INVALID_PPM_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_QUERY_INTERVAL: interval_ff <= csr_pwdata[15:0];
            REG_TIMEOUT:        timeout_ff  <= csr_pwdata[15:0];
            REG_INVALID_PPM:    invalid_ff  <= csr_pwdata[15:0];
            default:            ;
         endcase
      end
   end

   // request side
   assign accept  = req_tvalid && req_tready;
   assign byte_en = accept && (req_tuser == KIND_BYTE);
   assign tick_en = accept && (req_tuser == KIND_TICK);

   gsufp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   // tick counters
   assign tsq_inc = (tsq_ff == SAT16) ? tsq_ff : tsq_ff + 16'd1;
   assign tsf_inc = (tsf_ff == SAT16) ? tsf_ff : tsf_ff + 16'd1;
   assign due     = never_ff || (tsq_inc >= interval_ff);
   assign tmo     = tsf_inc > timeout_ff;

   always_comb begin
      tsq_in   = tsq_ff;
      tsf_in   = tsf_ff;
      never_in = never_ff;
      if (tick_en) begin
         tsq_in   = due ? 16'd0 : tsq_inc;
         never_in = never_ff && !due;
         tsf_in   = tmo ? 16'd0 : tsf_inc;
      end else if (frame.valid) begin
         tsf_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsq_ff   <= 16'd0;
         tsf_ff   <= 16'd0;
         never_ff <= 1'b1;
      end else begin
         tsq_ff   <= tsq_in;
         tsf_ff   <= tsf_in;
         never_ff <= never_in;
      end
   end

   // result register and slot sequencer
   assign out_last = single_ff || (slot_ff == SLOT_TIMEOUT) ||
                     (slot_ff == SLOT_QLAST && !tmo_ff);
   assign out_free = !busy_ff || (rsp_tready && out_last);
   assign req_tready = out_free;

   always_comb begin
      busy_in   = busy_ff;
      single_in = single_ff;
      fkind_in  = fkind_ff;
      fppm_in   = fppm_ff;
      slot_in   = slot_ff;
      tmo_in    = tmo_ff;
      if (busy_ff && rsp_tready) begin
         if (out_last) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_ff + 4'd1;
         end
      end
      if (frame.valid) begin
         busy_in   = 1'b1;
         single_in = 1'b1;
         fkind_in  = frame.fault ? RK_FAULT : RK_OK;
         fppm_in   = frame.fault ? invalid_ff : {3'd0, frame.conc};
      end else if (tick_en && (due || tmo)) begin
         busy_in   = 1'b1;
         single_in = 1'b0;
         slot_in   = due ? SLOT_FIRST : SLOT_TIMEOUT;
         tmo_in    = tmo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      single_ff <= single_in;
      fkind_ff  <= fkind_in;
      fppm_ff   <= fppm_in;
      slot_ff   <= slot_in;
      tmo_ff    <= tmo_in;
   end

   always_comb begin
      if (single_ff) begin
         out_kind = fkind_ff;
         out_ppm  = fppm_ff;
         out_tx   = 8'd0;
      end else if (slot_ff == SLOT_TIMEOUT) begin
         out_kind = RK_TIMEOUT;
         out_ppm  = invalid_ff;
         out_tx   = 8'd0;
      end else begin
         out_kind = RK_QUERY;
         out_ppm  = 16'd0;
         out_tx   = query_byte(slot_ff);
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = out_kind;
   assign rsp_tdata  = {out_tx, out_ppm};
   assign rsp_tlast  = out_last;

   // checks
   `GSUFP_ASSERT_NEXT(a_burst_continues, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   `GSUFP_ASSERT_NOW(a_take_when_free, clock, reset,
      req_tvalid && req_tready, !busy_ff || (rsp_tready && rsp_tlast))
   `GSUFP_ASSERT_NOW(a_query_slots, clock, reset,
      busy_ff && !single_ff && slot_ff != SLOT_TIMEOUT, rsp_tuser == RK_QUERY)
   `GSUFP_ASSERT_NOW(a_first_query_pending, clock, reset,
      never_ff, tsq_ff == 16'd0)

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for gas_sensor_uart_frame_parser
// drives received bytes and millisecond ticks on the request stream, writes
// the interval, timeout and invalid ppm registers between phases and checks
// every response against a cycle-free model of the parser and the scheduler
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gsufp_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ppm;
      logic [7:0]  tx;
      logic        last;
   } sensor_result_type;

   typedef logic [7:0] packet_type [9];

   typedef enum int {FR_QUERY, FR_UPLOAD, FR_ALIEN, FR_BAD_SUM} frame_kind_type;

   class sensor_tracker;
      logic [15:0]       interval_ms;
      logic [15:0]       timeout_limit;
      logic [15:0]       fault_ppm;
      logic [3:0]        position;
      logic [7:0]        stored [5];
      logic [7:0]        byte_sum;
      logic [15:0]       since_query;
      logic [15:0]       since_frame;
      bit                query_owed;
      logic [7:0]        poll_bytes [9];
      sensor_result_type awaited [$];
      int                errors;

      function new();
         interval_ms   = QUERY_INTERVAL_RESET;
         timeout_limit = TIMEOUT_RESET;
         fault_ppm     = INVALID_PPM_RESET;
         position      = POS_HUNT;
         byte_sum      = 8'd0;
         since_query   = 16'd0;
         since_frame   = 16'd0;
         query_owed    = 1'b1;
         errors        = 0;
         foreach (stored[i]) stored[i] = 8'd0;
         poll_bytes = '{8'hFF, 8'h01, 8'h86, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h79};
      endfunction

      function void set_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_QUERY_INTERVAL: interval_ms = value;
            REG_TIMEOUT:        timeout_limit = value;
            REG_INVALID_PPM:    fault_ppm = value;
            default: ;
         endcase
      endfunction

      function void take_request(logic kind, logic [7:0] rx);
         sensor_result_type batch [$];
         sensor_result_type r;
         logic              fault;
         logic [12:0]       conc;
         logic [7:0]        want_sum;
         bit                accepted;
         accepted = 1'b0;
         fault    = 1'b0;
         conc     = 13'd0;
         r        = '0;
         if (kind == KIND_BYTE) begin
            if (position == POS_HUNT) begin
               if (rx == START_BYTE) begin
                  position = POS_FIRST;
                  byte_sum = 8'd0;
               end
            end else if (position <= POS_LAST_SUM) begin
               if (position <= POS_LAST_ST) stored[position - 1] = rx;
               byte_sum = byte_sum + rx;
               position = position + 4'd1;
            end else begin
               position = POS_HUNT;
               want_sum = 8'd0 - byte_sum;
               if (want_sum == rx) begin
                  if (stored[0] == TYPE_QUERY) begin
                     accepted = 1'b1;
                     fault    = stored[1][7];
                     conc     = {stored[1][4:0], stored[2]};
                  end else if (stored[0] == TYPE_UPLOAD && stored[1] == CMD_UPLOAD) begin
                     accepted = 1'b1;
                     fault    = stored[3][7];
                     conc     = {stored[3][4:0], stored[4]};
                  end
               end
               if (accepted) begin
                  since_frame = 16'd0;
                  r.kind = fault ? RK_FAULT : RK_OK;
                  r.ppm  = fault ? fault_ppm : {3'b000, conc};
                  batch.push_back(r);
               end
            end
         end else begin
            if (since_query != SAT16) since_query = since_query + 16'd1;
            if (since_frame != SAT16) since_frame = since_frame + 16'd1;
            if (query_owed || since_query >= interval_ms) begin
               foreach (poll_bytes[i]) begin
                  r.kind = RK_QUERY;
                  r.ppm  = 16'd0;
                  r.tx   = poll_bytes[i];
                  batch.push_back(r);
               end
               since_query = 16'd0;
               query_owed  = 1'b0;
            end
            if (since_frame > timeout_limit) begin
               r.kind = RK_TIMEOUT;
               r.ppm  = fault_ppm;
               r.tx   = 8'd0;
               batch.push_back(r);
               since_frame = 16'd0;
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) awaited.push_back(batch[i]);
      endfunction

      function void flag(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      endfunction

      function void check_response(logic [1:0] kind, logic [15:0] ppm, logic [7:0] tx,
                                   logic last);
         sensor_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, actual kind %0d ppm %h tx %h",
                     $time, kind, ppm, tx);
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.kind) flag("kind", want.kind, kind);
         if (ppm !== want.ppm) flag("ppm", want.ppm, ppm);
         if (tx !== want.tx) flag("tx_byte", want.tx, tx);
         if (last !== want.last) flag("last", want.last, last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // rx_byte
   logic        req_tuser = 1'b0;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // ppm, tx_byte
   logic [1:0]  rsp_tuser;          // result_kind
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sensor_tracker tracker = new();
   int gap_pct = 25;
   int stall_pct = 25;
   int sent_items = 0;
   bit hold_request = 1'b0;
   int hold_cycles = 0;

   gas_sensor_uart_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_request(logic kind, logic [7:0] rx);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_request(kind, rx);
      sent_items++;
   endtask

   function automatic packet_type seal(packet_type p);
      logic [7:0] s;
      s = 8'd0;
      for (int i = 1; i < 8; i++) s = s + p[i];
      p[8] = 8'd0 - s;
      return p;
   endfunction

   function automatic packet_type make_frame(frame_kind_type variant);
      packet_type p;
      p[0] = START_BYTE;
      for (int i = 1; i < 9; i++) p[i] = 8'($urandom_range(0, 255));
      case (variant)
         FR_QUERY, FR_BAD_SUM: begin
            p[1] = TYPE_QUERY;
            p[2][7] = ($urandom_range(0, 3) == 0);
         end
         FR_UPLOAD: begin
            p[1] = TYPE_UPLOAD;
            p[2] = CMD_UPLOAD;
            p[4][7] = ($urandom_range(0, 3) == 0);
         end
         default: ;
      endcase
      p = seal(p);
      if (variant == FR_BAD_SUM) p[8] = p[8] + 8'($urandom_range(1, 255));
      return p;
   endfunction

   task automatic send_packet(packet_type p, int tick_pct);
      for (int i = 0; i < 9; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_request(KIND_TICK, 8'($urandom_range(0, 255)));
         send_request(KIND_BYTE, p[i]);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   task automatic run_mixed(int count);
      int goal;
      int pick;
      int shape;
      frame_kind_type variant;
      goal = sent_items + count;
      while (sent_items < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            shape = $urandom_range(0, 99);
            if (shape < 40) variant = FR_QUERY;
            else if (shape < 75) variant = FR_UPLOAD;
            else if (shape < 87) variant = FR_ALIEN;
            else variant = FR_BAD_SUM;
            send_packet(make_frame(variant), 15);
         end else if (pick < 80) begin
            send_request(KIND_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) send_request(KIND_TICK, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // response side
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_response(rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16], rsp_tlast);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles  = 60;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // request side and register phases
   initial begin
      packet_type p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_register(REG_UNUSED, 16'h1234);

      // first tick sends the query, then frames with edge contents
      send_request(KIND_TICK, 8'h00);
      send_request(KIND_TICK, 8'hFF);
      p = seal('{8'hFF, 8'h86, 8'h1F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_packet(p, 0);
      p = seal('{8'hFF, 8'h01, 8'h03, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
      send_packet(p, 0);
      p = seal('{8'hFF, 8'h01, 8'h03, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_packet(p, 0);
      settle();

      // tightest schedule: query every tick, timeout every other tick
      write_register(REG_QUERY_INTERVAL, 16'd1);
      write_register(REG_TIMEOUT, 16'd1);
      write_register(REG_INVALID_PPM, 16'd0);
      run_mixed(60);
      settle();

      // short random schedule with the receiver held off for a while
      write_register(REG_QUERY_INTERVAL, 16'($urandom_range(2, 20)));
      write_register(REG_TIMEOUT, 16'($urandom_range(3, 30)));
      write_register(REG_INVALID_PPM, 16'($urandom_range(0, 65535)));
      hold_request = 1'b1;
      repeat (24) send_request(KIND_TICK, 8'($urandom_range(0, 255)));
      run_mixed(50);
      settle();

      // widest schedule, run without idling
      write_register(REG_QUERY_INTERVAL, 16'hFFFF);
      write_register(REG_TIMEOUT, 16'hFFFE);
      write_register(REG_INVALID_PPM, 16'hFFFF);
      gap_pct = 0;
      stall_pct = 0;
      run_mixed(40);
      gap_pct = 25;
      stall_pct = 25;
      settle();

      write_register(REG_QUERY_INTERVAL, 16'd7);
      write_register(REG_TIMEOUT, 16'd15);
      write_register(REG_INVALID_PPM, 16'($urandom_range(0, 65535)));
      run_mixed(60);

      settle();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/gsufp_pkg.sv
hw/rtl/gsufp_parser.sv
hw/rtl/gas_sensor_uart_frame_parser.sv
verif/testbench.sv
